// ===== rtl/dps_pkg.sv =====
// Package with the shared types and constants of the double power by squaring block.
`default_nettype none
package dps_pkg;

   localparam logic [63:0] ONE_BITS  = 64'h3FF0_0000_0000_0000;
   localparam logic [63:0] DNAN_BITS = 64'hFFF8_0000_0000_0000;

   localparam int MANT_W = 53;
   localparam int PROD_W = 2 * MANT_W;
   localparam int XEXP_W = 14;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_DIV,
      SEQ_LOOP,
      SEQ_MUL_ACC,
      SEQ_MUL_SQ,
      SEQ_MUL_FIN,
      SEQ_OUT
   } seq_state_type;

   typedef enum logic [2:0] {
      FPU_IDLE,
      FPU_MULP,
      FPU_NORMX,
      FPU_DIVS,
      FPU_NORM,
      FPU_ROUND,
      FPU_DONE
   } fpu_state_type;

   typedef struct packed {
      logic start;
      logic div;
   } fpu_ctl_type;

endpackage
`default_nettype wire

// ===== rtl/dps_fpu.sv =====
// Shared iterative double unit: multiply a by b, or reciprocal of a, rounded to nearest even.
`default_nettype none
module dps_fpu
   import dps_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire fpu_ctl_type ctl,
   input  wire logic [63:0] op_a,
   input  wire logic [63:0] op_b,
   output logic             done,
   output logic [63:0]      result
);

   fpu_state_type              ust_ff, ust_in;
   logic                       sign_ff, sign_in;
   logic signed [XEXP_W-1:0]   xexp_ff, xexp_in;
   logic [PROD_W-1:0]          acc_ff, acc_in;
   logic                       sticky_ff, sticky_in;
   logic [MANT_W-1:0]          ma_ff, ma_in;
   logic [MANT_W-1:0]          mb_ff, mb_in;
   logic [53:0]                prod_ff, prod_in;
   logic [6:0]                 step_ff, step_in;
   logic [53:0]                rem_ff, rem_in;
   logic [63:0]                res_ff, res_in;

   logic [10:0]              ea, eb;
   logic [51:0]              fa, fb;
   logic                     a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
   logic signed [XEXP_W-1:0] eav, ebv;
   logic [26:0]              pa, pb;
   logic [1:0]               pj;
   logic [PROD_W-1:0]        addend;
   logic [53:0]              rtwo;
   logic                     rnd_inc, rnd_st;
   logic [53:0]              rnd_m;
   logic [52:0]              fin_m;
   logic signed [XEXP_W-1:0] fin_x;
   logic [10:0]              fin_e;

   assign ea     = op_a[62:52];
   assign eb     = op_b[62:52];
   assign fa     = op_a[51:0];
   assign fb     = op_b[51:0];
   assign a_nan  = (ea == 11'h7FF) && (fa != 52'd0);
   assign b_nan  = (eb == 11'h7FF) && (fb != 52'd0);
   assign a_inf  = (ea == 11'h7FF) && (fa == 52'd0);
   assign b_inf  = (eb == 11'h7FF) && (fb == 52'd0);
   assign a_zero = (ea == 11'd0) && (fa == 52'd0);
   assign b_zero = (eb == 11'd0) && (fb == 52'd0);
   assign eav    = (ea == 11'd0) ? XEXP_W'(1) : $signed({3'b000, ea});
   assign ebv    = (eb == 11'd0) ? XEXP_W'(1) : $signed({3'b000, eb});

   always_comb begin
      pa = step_ff[1] ? ma_ff[52:26] : {1'b0, ma_ff[25:0]};
      pb = step_ff[0] ? mb_ff[52:26] : {1'b0, mb_ff[25:0]};
      pj = 2'(step_ff - 7'd1);
      unique case (pj)
         2'd0:    addend = {52'd0, prod_ff};
         2'd3:    addend = {prod_ff, 52'd0};
         default: addend = {26'd0, prod_ff, 26'd0};
      endcase
      rtwo    = {rem_ff[52:0], 1'b0};
      rnd_st  = sticky_ff | (|acc_ff[51:0]);
      rnd_inc = acc_ff[52] & (rnd_st | acc_ff[53]);
      rnd_m   = {1'b0, acc_ff[105:53]} + {53'd0, rnd_inc};
      fin_m   = rnd_m[53] ? rnd_m[53:1] : rnd_m[52:0];
      fin_x   = rnd_m[53] ? xexp_ff + XEXP_W'(1) : xexp_ff;
      fin_e   = fin_m[52] ? fin_x[10:0] : 11'd0;
   end

   always_comb begin
      ust_in    = ust_ff;
      sign_in   = sign_ff;
      xexp_in   = xexp_ff;
      acc_in    = acc_ff;
      sticky_in = sticky_ff;
      ma_in     = ma_ff;
      mb_in     = mb_ff;
      prod_in   = prod_ff;
      step_in   = step_ff;
      rem_in    = rem_ff;
      res_in    = res_ff;
      unique case (ust_ff)
         FPU_IDLE, FPU_DONE: begin
            ust_in = FPU_IDLE;
            if (ctl.start) begin
               acc_in    = '0;
               sticky_in = 1'b0;
               step_in   = '0;
               ust_in    = FPU_DONE;
               if (ctl.div) begin
                  sign_in = op_a[63];
                  if (a_nan) begin
                     res_in = op_a | 64'h0008_0000_0000_0000;
                  end else if (a_inf) begin
                     res_in = {op_a[63], 63'd0};
                  end else if (a_zero) begin
                     res_in = {op_a[63], 11'h7FF, 52'd0};
                  end else begin
                     ma_in   = {ea != 11'd0, fa};
                     xexp_in = eav;
                     ust_in  = FPU_NORMX;
                  end
               end else begin
                  sign_in = op_a[63] ^ op_b[63];
                  if (a_nan) begin
                     res_in = op_a | 64'h0008_0000_0000_0000;
                  end else if (b_nan) begin
                     res_in = op_b | 64'h0008_0000_0000_0000;
                  end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
                     res_in = DNAN_BITS;
                  end else if (a_inf || b_inf) begin
                     res_in = {op_a[63] ^ op_b[63], 11'h7FF, 52'd0};
                  end else if (a_zero || b_zero) begin
                     res_in = {op_a[63] ^ op_b[63], 63'd0};
                  end else begin
                     ma_in   = {ea != 11'd0, fa};
                     mb_in   = {eb != 11'd0, fb};
                     xexp_in = eav + ebv - XEXP_W'(1022);
                     ust_in  = FPU_MULP;
                  end
               end
            end
         end
         FPU_MULP: begin
            if (step_ff < 7'd4) begin
               prod_in = pa * pb;
            end
            if (step_ff != 7'd0) begin
               acc_in = acc_ff + addend;
            end
            step_in = step_ff + 7'd1;
            if (step_ff == 7'd4) begin
               ust_in = FPU_NORM;
            end
         end
         FPU_NORMX: begin
            if (ma_ff[52]) begin
               mb_in   = ma_ff;
               xexp_in = XEXP_W'(2046) - xexp_ff;
               rem_in  = 54'd1 << 51;
               ust_in  = FPU_DIVS;
            end else begin
               ma_in   = {ma_ff[51:0], 1'b0};
               xexp_in = xexp_ff - XEXP_W'(1);
            end
         end
         FPU_DIVS: begin
            if (rtwo >= {1'b0, mb_ff}) begin
               rem_in = rtwo - {1'b0, mb_ff};
               acc_in = {acc_ff[104:0], 1'b1};
            end else begin
               rem_in = rtwo;
               acc_in = {acc_ff[104:0], 1'b0};
            end
            step_in = step_ff + 7'd1;
            if (step_ff == 7'(PROD_W - 1)) begin
               sticky_in = (rtwo != {1'b0, mb_ff});
               ust_in    = FPU_NORM;
            end
         end
         FPU_NORM: begin
            if (xexp_ff < -XEXP_W'(108)) begin
               sticky_in = sticky_ff | (|acc_ff);
               acc_in    = '0;
               xexp_in   = XEXP_W'(1);
            end else if (!acc_ff[105] && (xexp_ff > XEXP_W'(1))) begin
               acc_in  = {acc_ff[104:0], 1'b0};
               xexp_in = xexp_ff - XEXP_W'(1);
            end else if (xexp_ff < XEXP_W'(1)) begin
               sticky_in = sticky_ff | acc_ff[0];
               acc_in    = {1'b0, acc_ff[105:1]};
               xexp_in   = xexp_ff + XEXP_W'(1);
            end else begin
               ust_in = FPU_ROUND;
            end
         end
         FPU_ROUND: begin
            if (fin_x >= XEXP_W'(2047)) begin
               res_in = {sign_ff, 11'h7FF, 52'd0};
            end else begin
               res_in = {sign_ff, fin_e, fin_m[51:0]};
            end
            ust_in = FPU_DONE;
         end
         default: begin
            ust_in = FPU_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ust_ff <= FPU_IDLE;
      end else begin
         ust_ff <= ust_in;
      end
      sign_ff   <= sign_in;
      xexp_ff   <= xexp_in;
      acc_ff    <= acc_in;
      sticky_ff <= sticky_in;
      ma_ff     <= ma_in;
      mb_ff     <= mb_in;
      prod_ff   <= prod_in;
      step_ff   <= step_in;
      rem_ff    <= rem_in;
      res_ff    <= res_in;
   end

   assign done   = (ust_ff == FPU_DONE);
   assign result = res_ff;

endmodule
`default_nettype wire

// ===== rtl/double_power_by_squaring_top.sv =====
// Top level: square-and-multiply sequencer around the shared double unit.
// Exponents 0 and 1 bypass the arithmetic unit and go straight to the output stage; otherwise each
// exponent bit costs up to two double multiplies, and a negative exponent first costs one reciprocal.
// Throughput: one word at a time; req_tready is high only when the sequencer is idle.
// Subnormal operands or results lengthen a multiply or a reciprocal by extra normalising shift steps.
// Reset is synchronous and active high and clears the control state only.
`default_nettype none
module double_power_by_squaring_top
   import dps_pkg::*;
#(
   parameter int EXP_WIDTH = 32
)(
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // Fields from bit 0: base_bits (64), exponent (EXP_WIDTH), zero fill.
   input  wire logic [((64 + EXP_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // Fields from bit 0: result_bits (64).
   output logic [63:0]                                 rsp_tdata
);

   seq_state_type          st_ff, st_in;
   logic [63:0]            base_ff, base_in;
   logic [63:0]            acc_ff, acc_in;
   logic [63:0]            res_ff, res_in;
   logic [EXP_WIDTH-1:0]   mag_ff, mag_in;
   logic [63:0]            out_ff, out_in;
   logic                   out_vld_ff, out_vld_in;

   logic [63:0]            in_base;
   logic [EXP_WIDTH-1:0]   in_exp;
   fpu_ctl_type            fctl;
   logic [63:0]            fa, fb;
   logic                   fdone;
   logic [63:0]            fres;
   logic                   req_acc;

   assign in_base = req_tdata[63:0];
   assign in_exp  = req_tdata[64 +: EXP_WIDTH];
   assign req_acc = req_tvalid && req_tready;

   always_comb begin
      st_in      = st_ff;
      base_in    = base_ff;
      acc_in     = acc_ff;
      res_in     = res_ff;
      mag_in     = mag_ff;
      out_in     = out_ff;
      out_vld_in = out_vld_ff && !rsp_tready;
      fctl.start = 1'b0;
      fctl.div   = 1'b0;
      fa         = acc_ff;
      fb         = base_ff;
      unique case (st_ff)
         SEQ_IDLE: begin
            fa = in_base;
            if (req_acc) begin
               acc_in = ONE_BITS;
               if (in_exp == '0) begin
                  res_in = ONE_BITS;
                  st_in  = SEQ_OUT;
               end else if (in_exp == EXP_WIDTH'(1)) begin
                  res_in = in_base;
                  st_in  = SEQ_OUT;
               end else if (in_exp[EXP_WIDTH-1]) begin
                  mag_in     = '0 - in_exp;
                  fctl.start = 1'b1;
                  fctl.div   = 1'b1;
                  st_in      = SEQ_DIV;
               end else begin
                  mag_in  = in_exp;
                  base_in = in_base;
                  st_in   = SEQ_LOOP;
               end
            end
         end
         SEQ_DIV: begin
            if (fdone) begin
               base_in = fres;
               st_in   = SEQ_LOOP;
            end
         end
         SEQ_LOOP: begin
            fctl.start = 1'b1;
            if (mag_ff > EXP_WIDTH'(1)) begin
               if (mag_ff[0]) begin
                  st_in = SEQ_MUL_ACC;
               end else begin
                  fa    = base_ff;
                  st_in = SEQ_MUL_SQ;
               end
            end else begin
               st_in = SEQ_MUL_FIN;
            end
         end
         SEQ_MUL_ACC: begin
            fa = base_ff;
            if (fdone) begin
               acc_in     = fres;
               fctl.start = 1'b1;
               st_in      = SEQ_MUL_SQ;
            end
         end
         SEQ_MUL_SQ: begin
            if (fdone) begin
               base_in = fres;
               mag_in  = mag_ff >> 1;
               st_in   = SEQ_LOOP;
            end
         end
         SEQ_MUL_FIN: begin
            if (fdone) begin
               res_in = fres;
               st_in  = SEQ_OUT;
            end
         end
         SEQ_OUT: begin
            if (!out_vld_ff || rsp_tready) begin
               out_in     = res_ff;
               out_vld_in = 1'b1;
               st_in      = SEQ_IDLE;
            end
         end
         default: begin
            st_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= SEQ_IDLE;
         out_vld_ff <= 1'b0;
      end else begin
         st_ff      <= st_in;
         out_vld_ff <= out_vld_in;
      end
      base_ff <= base_in;
      acc_ff  <= acc_in;
      res_ff  <= res_in;
      mag_ff  <= mag_in;
      out_ff  <= out_in;
   end

   dps_fpu u_fpu (
      .clock  (clock),
      .reset  (reset),
      .ctl    (fctl),
      .op_a   (fa),
      .op_b   (fb),
      .done   (fdone),
      .result (fres)
   );

   assign req_tready = (st_ff == SEQ_IDLE);
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_ff;

`ifndef ASSERT_OFF
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("Result word changed or dropped while it was waiting.");

   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_tready)
      else $error("Block still ready right after accepting a word.");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      fdone |-> (st_ff == SEQ_DIV || st_ff == SEQ_MUL_ACC || st_ff == SEQ_MUL_SQ
                 || st_ff == SEQ_MUL_FIN))
      else $error("Arithmetic unit finished while the sequencer was not waiting.");

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      fctl.start |-> (st_ff == SEQ_IDLE || st_ff == SEQ_LOOP || fdone))
      else $error("Arithmetic unit started while it was still busy.");
`endif

endmodule
`default_nettype wire
